[design/mesh_element_vertex_hash_core_defines.svh]
// ---------------------------------------------------------------------------
// mesh_element_vertex_hash_core_defines
// Assertion macros for the vertex hash core.
// ---------------------------------------------------------------------------
`ifndef MESH_ELEMENT_VERTEX_HASH_CORE_DEFINES_SVH
`define MESH_ELEMENT_VERTEX_HASH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, disabled in reset.
`define MEVH_ASSERT_SAME(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("mevh check failed");
// Next-cycle implication, checked on clk, disabled in reset.
`define MEVH_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("mevh check failed");
`else
`define MEVH_ASSERT_SAME(label, a, c)
`define MEVH_ASSERT_NEXT(label, a, c)
`endif

`endif

[design/mevh_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mevh_pkg
// Types and codes shared by the vertex hash core.
// ---------------------------------------------------------------------------
package mevh_pkg;

  localparam int NUM_VERT_FIELDS = 8;
  localparam int ID_W            = 12;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_COUNT = 3'd1;
  localparam logic [2:0] STAT_EMPTY     = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_RANGE     = 3'd5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic CFG_VERTEX_LIMIT  = 1'b0;
  localparam logic CFG_ELEMENT_LIMIT = 1'b1;

  typedef struct packed {
    logic                                  command;
    logic [3:0]                            vertex_count;
    logic [ID_W-1:0]                       element_index;
    logic [NUM_VERT_FIELDS-1:0][ID_W-1:0] vert;
  } item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SORT, S_FILL_RD, S_FILL_CHK,
    S_INS_WR, S_INS_ROW, S_SCAN_RD, S_SCAN_ROW, S_SCAN_CMP, S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic sort_step;
    logic fill_rd;
    logic fill_chk;
    logic ins_wr;
    logic ins_row;
    logic scan_rd;
    logic scan_row;
    logic scan_cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic err;
    logic lookup;
    logic full;
    logic empty;
    logic sort_last;
    logic hit;
    logic scan_last;
    logic out_busy;
  } stat_t;

endpackage

[design/mevh_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mevh_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mevh_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/mevh_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mevh_ctrl
// Sequencer: clear sweep, check, sort, bucket insert or scan, emit.
// ---------------------------------------------------------------------------
module mevh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  mevh_pkg::stat_t stat,
  output mevh_pkg::cmd_t  cmd
);
  import mevh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:     if (s_tvalid) state_next = S_CHECK;
      S_CHECK:    state_next = stat.err ? S_DONE : S_SORT;
      S_SORT:     if (stat.sort_last) state_next = S_FILL_RD;
      S_FILL_RD:  state_next = S_FILL_CHK;
      S_FILL_CHK: begin
        if (stat.lookup) begin
          state_next = stat.empty ? S_DONE : S_SCAN_RD;
        end else begin
          state_next = stat.full ? S_DONE : S_INS_WR;
        end
      end
      S_INS_WR:   state_next = S_INS_ROW;
      S_INS_ROW:  state_next = S_DONE;
      S_SCAN_RD:  state_next = S_SCAN_ROW;
      S_SCAN_ROW: state_next = S_SCAN_CMP;
      S_SCAN_CMP: state_next = (stat.hit || stat.scan_last) ? S_DONE : S_SCAN_RD;
      S_DONE:     if (!stat.out_busy) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_CLEAR:    cmd.clear_step = 1'b1;
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_SORT:     cmd.sort_step = 1'b1;
      S_FILL_RD:  cmd.fill_rd = 1'b1;
      S_FILL_CHK: cmd.fill_chk = 1'b1;
      S_INS_WR:   cmd.ins_wr = 1'b1;
      S_INS_ROW:  cmd.ins_row = 1'b1;
      S_SCAN_RD:  cmd.scan_rd = 1'b1;
      S_SCAN_ROW: cmd.scan_row = 1'b1;
      S_SCAN_CMP: cmd.scan_cmp = 1'b1;
      S_DONE:     cmd.emit = !stat.out_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

[design/mevh_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mevh_dp
// Datapath: item registers, sorter, tables and result register.
// ---------------------------------------------------------------------------
module mevh_dp #(
  parameter int MAX_VERTS     = 8,
  parameter int VERTEX_SLOTS  = 4096,
  parameter int ELEMENT_SLOTS = 4096,
  parameter int BUCKET_DEPTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mevh_pkg::item_t              item,
  input  logic [11:0]                  vertex_limit,
  input  logic [12:0]                  element_limit,
  input  mevh_pkg::cmd_t               cmd,
  output mevh_pkg::stat_t              stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [mevh_pkg::ID_W-1:0]    out_found
);
  import mevh_pkg::*;

  localparam int VA        = $clog2(VERTEX_SLOTS);
  localparam int EA        = $clog2(ELEMENT_SLOTS);
  localparam int DW        = $clog2(BUCKET_DEPTH);
  localparam int FW        = $clog2(BUCKET_DEPTH + 1);
  localparam int SPW       = $clog2(MAX_VERTS);
  localparam int ENT_DEPTH = VERTEX_SLOTS * (2 ** DW);
  localparam int CLEAR_LEN = (VERTEX_SLOTS > ELEMENT_SLOTS) ? VERTEX_SLOTS : ELEMENT_SLOTS;
  localparam int CW        = $clog2(CLEAR_LEN);
  localparam int ROW_W     = MAX_VERTS * ID_W;

  logic                                 command;
  logic [3:0]                           count;
  logic [ID_W-1:0]                      elem;
  logic [MAX_VERTS-1:0][ID_W-1:0]       ids, ids_next;
  logic [2:0]                           status, status_next;
  logic [ID_W-1:0]                      found;
  logic [SPW-1:0]                       sort_pass;
  logic [CW-1:0]                        clr_addr;
  logic [FW-1:0]                        fill;
  logic [FW-1:0]                        scan_k;
  logic [ID_W-1:0]                      ent;
  logic                                 ent_ok;
  logic                                 clearing;
  logic [VA-1:0]                        bucket;
  logic                                 match;
  logic [MAX_VERTS-1:0][ID_W-1:0]       row_merge;
  logic [MAX_VERTS-1:0][ID_W-1:0]       load_ids;

  logic                 fill_we;
  logic [VA-1:0]        fill_waddr;
  logic [FW-1:0]        fill_wdata, fill_rdata;
  logic [VA+DW-1:0]     ent_waddr, ent_raddr;
  logic [ID_W-1:0]      ent_rdata;
  logic                 row_we, row_re;
  logic [EA-1:0]        row_waddr, row_raddr;
  logic [ROW_W-1:0]     row_wdata, row_rdata;
  logic [MAX_VERTS-1:0][ID_W-1:0] row_old;

  assign clearing = cmd.clear_step;
  assign bucket   = VA'(ids[0]);
  assign row_old  = row_rdata;

  // Precheck of the incoming word; unused id slots pad high so they sort last.
  always_comb begin
    status_next = STAT_OK;
    for (int i = 0; i < MAX_VERTS; i++) begin
      load_ids[i] = (4'(i) < item.vertex_count) ? item.vert[i] : {ID_W{1'b1}};
    end
    if (item.vertex_count == 4'd0 || 32'(item.vertex_count) > MAX_VERTS) begin
      status_next = STAT_BAD_COUNT;
    end else begin
      for (int i = 0; i < MAX_VERTS; i++) begin
        if (4'(i) < item.vertex_count &&
            (item.vert[i] == '0 || item.vert[i] > vertex_limit ||
             32'(item.vert[i]) >= VERTEX_SLOTS)) begin
          status_next = STAT_RANGE;
        end
      end
      if (item.command == CMD_INSERT &&
          (13'(item.element_index) >= element_limit ||
           32'(item.element_index) >= ELEMENT_SLOTS)) begin
        status_next = STAT_RANGE;
      end
    end
  end

  // One odd-even transposition pass.
  always_comb begin
    ids_next = ids;
    for (int j = 0; j < MAX_VERTS - 1; j++) begin
      if (1'(j) == sort_pass[0] && ids[j] > ids[j+1]) begin
        ids_next[j]   = ids[j+1];
        ids_next[j+1] = ids[j];
      end
    end
  end

  always_comb begin
    match = ent_ok;
    for (int i = 0; i < MAX_VERTS; i++) begin
      if (4'(i) < count && row_old[i] != ids[i]) match = 1'b0;
      row_merge[i] = (4'(i) < count) ? ids[i] : row_old[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) clr_addr <= clr_addr + 1'b1;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command   <= item.command;
      count     <= item.vertex_count;
      elem      <= item.element_index;
      ids       <= load_ids;
      status    <= status_next;
      found     <= '0;
      sort_pass <= '0;
    end
    if (cmd.sort_step) begin
      ids       <= ids_next;
      sort_pass <= sort_pass + 1'b1;
    end
    if (cmd.fill_chk) begin
      fill   <= fill_rdata;
      scan_k <= '0;
      if (command == CMD_INSERT && 32'(fill_rdata) >= BUCKET_DEPTH) status <= STAT_FULL;
      if (command == CMD_LOOKUP && fill_rdata == '0) status <= STAT_EMPTY;
    end
    if (cmd.scan_row) begin
      ent    <= ent_rdata;
      ent_ok <= 32'(ent_rdata) < ELEMENT_SLOTS;
    end
    if (cmd.scan_cmp) begin
      scan_k <= scan_k + 1'b1;
      if (match) begin
        found <= ent;
      end else if (scan_k + 1'b1 == fill) begin
        status <= STAT_NOT_FOUND;
      end
    end
    if (cmd.emit) begin
      out_status <= status;
      out_found  <= found;
    end
  end

  // Table port steering: the clear sweep owns the fill and row table write ports while active.
  always_comb begin
    fill_we    = clearing ? (32'(clr_addr) < VERTEX_SLOTS) : cmd.ins_wr;
    fill_waddr = clearing ? VA'(clr_addr) : bucket;
    fill_wdata = clearing ? '0 : fill + 1'b1;
    ent_waddr  = {bucket, DW'(fill)};
    ent_raddr  = {bucket, DW'(scan_k)};
    row_we     = clearing ? (32'(clr_addr) < ELEMENT_SLOTS) : cmd.ins_row;
    row_waddr  = clearing ? EA'(clr_addr) : EA'(elem);
    row_wdata  = clearing ? '0 : row_merge;
    row_re     = cmd.ins_wr || cmd.scan_row;
    row_raddr  = cmd.ins_wr ? EA'(elem) : EA'(ent_rdata);
  end

  mevh_ram #(.WIDTH(FW), .DEPTH(VERTEX_SLOTS)) u_fill (
    .clk, .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .re(cmd.fill_rd), .raddr(bucket), .rdata(fill_rdata)
  );

  mevh_ram #(.WIDTH(ID_W), .DEPTH(ENT_DEPTH)) u_entries (
    .clk, .we(cmd.ins_wr), .waddr(ent_waddr), .wdata(elem),
    .re(cmd.scan_rd), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  mevh_ram #(.WIDTH(ROW_W), .DEPTH(ELEMENT_SLOTS)) u_rows (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
  );

  always_comb begin
    stat.clear_last = clr_addr == CW'(CLEAR_LEN - 1);
    stat.err        = status != STAT_OK;
    stat.lookup     = command == CMD_LOOKUP;
    stat.full       = 32'(fill_rdata) >= BUCKET_DEPTH;
    stat.empty      = fill_rdata == '0;
    stat.sort_last  = sort_pass == SPW'(MAX_VERTS - 1);
    stat.hit        = match;
    stat.scan_last  = scan_k + 1'b1 == fill;
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

[design/mesh_element_vertex_hash_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mesh_element_vertex_hash_core
// Element lookup by sorted vertex set, bucketed on the smallest vertex id.
// ---------------------------------------------------------------------------
// After reset the core sweeps its bucket fill table and element vertex table
// to zero, one row per cycle, across max(VERTEX_SLOTS, ELEMENT_SLOTS) rows
// (4096 at the defaults); s_tready stays low during the sweep while config
// writes are still taken. Each word is handled alone: accept, check,
// MAX_VERTS odd-even sort passes, the bucket fill read, then the entry and
// vertex row writes to insert, or, for a lookup, per bucket entry scanned,
// an entry read, a vertex row read and a compare; then the result is posted.
// An insert stops early when its bucket is already full, a lookup when its
// bucket is empty; a scan ends at a match or at the last entry. Errors found
// by the check go straight to posting the result.
// The result sits in an output register, so the next word is accepted while
// it waits; if that register still holds an unaccepted result when the next
// one is ready, the core holds in its final cycle until the sink takes it.
// ---------------------------------------------------------------------------
`include "mesh_element_vertex_hash_core_defines.svh"

module mesh_element_vertex_hash_core #(
  parameter int MAX_VERTS     = 8,
  parameter int VERTEX_SLOTS  = 4096,
  parameter int ELEMENT_SLOTS = 4096,
  parameter int BUCKET_DEPTH  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // vertex_count[3:0], element_index[15:4], vert_a..vert_h 12 bits each from 16
  input  logic [111:0]  s_tdata,
  // command
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // found_index[11:0], zero fill [15:12]
  output logic [15:0]   m_tdata,
  // status
  output logic [2:0]    m_tuser,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [12:0]   cfg_data
);
  import mevh_pkg::*;

  logic [11:0]     vertex_limit;
  logic [12:0]     element_limit;
  item_t           item;
  cmd_t            cmd;
  stat_t           stat;
  logic [ID_W-1:0] found;

  // Limit registers; the check reads them when a word is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit  <= 12'd4095;
      element_limit <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_LIMIT:  vertex_limit  <= cfg_data[11:0];
        CFG_ELEMENT_LIMIT: element_limit <= cfg_data;
        default:           vertex_limit  <= vertex_limit;
      endcase
    end
  end

  // Unpack the input word.
  always_comb begin
    item.command       = s_tuser;
    item.vertex_count  = s_tdata[3:0];
    item.element_index = s_tdata[15:4];
    for (int i = 0; i < NUM_VERT_FIELDS; i++) begin
      item.vert[i] = s_tdata[16 + i*ID_W +: ID_W];
    end
  end

  mevh_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .stat, .cmd
  );

  mevh_dp #(
    .MAX_VERTS(MAX_VERTS), .VERTEX_SLOTS(VERTEX_SLOTS),
    .ELEMENT_SLOTS(ELEMENT_SLOTS), .BUCKET_DEPTH(BUCKET_DEPTH)
  ) u_dp (
    .clk, .rst, .item, .vertex_limit, .element_limit, .cmd, .stat,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_status(m_tuser),
    .out_found(found)
  );

  assign m_tdata = {4'd0, found};

  // Busy for at least the check cycle after each accepted word.
  `MEVH_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // Only a successful lookup reports a nonzero index.
  `MEVH_ASSERT_SAME(a_found_zero_on_error, m_tvalid && m_tuser != STAT_OK, m_tdata == 16'd0)
  // The clear sweep runs right after reset, so no word is taken then.
  `MEVH_ASSERT_SAME(a_no_accept_after_reset, $past(rst), !s_tready)

endmodule
